// ----- rtl/prime_field_alu_defines.svh -----
// Assertion macros shared by the prime field ALU modules.
`ifndef PRIME_FIELD_ALU_DEFINES_SVH
`define PRIME_FIELD_ALU_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that the property holds at every clock edge outside reset.
`define PFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that the expression never holds outside reset.
`define PFA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PFA_ASSERT(label, clk, rst_n, prop, msg)
`define PFA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int SW = DATA_WIDTH + 2;
    localparam int STEP_W = $clog2(2 * DATA_WIDTH + 1);

    localparam logic [DATA_WIDTH-1:0] MOD_RESET = DATA_WIDTH'(65521);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;
    localparam logic [2:0] MODE_INV = 3'd5;
    localparam logic [2:0] MODE_EQ  = 3'd6;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ZERO  = 2'd1;
    localparam logic [1:0] STAT_NOINV = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_NEG,
        OP_INV,
        OP_EQ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } entry_t;

    typedef struct packed {
        logic                    start;
        logic                    wide;
        logic [2*DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_WAIT_A,
        ST_RED_B,
        ST_WAIT_B,
        ST_EXEC,
        ST_EUC,
        ST_EUC_WAIT,
        ST_POST_INV,
        ST_MRED,
        ST_MWAIT
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/prime_field_alu.sv -----
// Arithmetic unit over the integers modulo a configurable modulus.
// Input channel (in_valid/in_ready) carries one word: mode, operand_a, operand_b.
// Output channel (out_valid/out_ready) returns one word per input: result, status.
// The user must write the modulus through cfg_wr_en/cfg_wr_data while the unit is idle;
// the unit does not enforce this. Values below 2 act as 2. Operands are reduced before use.
// A two-entry queue sits behind the input, so new words are taken while a
// result waits in the output register. Items are worked one at a time.
// Add, subtract, negate and equal pass through the operand checks and the execute
// state; an operand at or above the modulus is first reduced by the divider;
// multiply adds a wide reduction of the product; invert adds one divider pass per
// Euclid step (up to about 24 steps for 16-bit moduli), and divide adds that plus a
// product reduction. Time is set by the shared bit-serial divider, which retires
// one quotient bit per cycle for every remainder.
// Reset loads the modulus with 65521 and empties the queue and output register.
// When the receiver stalls, the result holds; the queue fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module prime_field_alu (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [2:0]                     mode,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] operand_a,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] operand_b,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pfa_pkg::DATA_WIDTH-1:0]      result,
    output logic [1:0]                          status
);
    import pfa_pkg::*;

    logic [DATA_WIDTH-1:0] modulus_reg;
    logic                  q_valid;
    logic                  q_pop;
    entry_t                q_entry;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // The modulus register is the only configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data;
        end
    end

    // Front end: decodes the mode and buffers words.
    pfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    // Back end: sequences reduction, arithmetic and the Euclid inverse.
    pfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (modulus_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .status    (status)
    );

    // Shared divider used for every remainder and Euclid quotient.
    pfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/pfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfa_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [2:0]                   mode,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] operand_a,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] operand_b,
    output logic                              q_valid,
    output pfa_pkg::entry_t                   q_entry,
    input  wire logic                         q_pop
);
    import pfa_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    entry_t     in_entry;

    // Decode the mode into an operation class; the unused code becomes a no-op.
    always_comb
    begin
        in_entry.a = operand_a;
        in_entry.b = operand_b;
        unique case (mode)
            MODE_ADD: in_entry.op = OP_ADD;
            MODE_SUB: in_entry.op = OP_SUB;
            MODE_MUL: in_entry.op = OP_MUL;
            MODE_DIV: in_entry.op = OP_DIV;
            MODE_NEG: in_entry.op = OP_NEG;
            MODE_INV: in_entry.op = OP_INV;
            MODE_EQ:  in_entry.op = OP_EQ;
            default:  in_entry.op = OP_NONE;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pfa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "prime_field_alu_defines.svh"

module pfa_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pfa_pkg::div_req_t req,
    output pfa_pkg::div_rsp_t      rsp
);
    import pfa_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [STEP_W-1:0] STEPS_NARROW = STEP_W'(W);
    localparam logic [STEP_W-1:0] STEPS_WIDE   = STEP_W'(2 * W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [W-1:0]      rem_reg;
    logic [2*W-1:0]    dq_reg;
    logic [W-1:0]      dsr_reg;
    logic [W:0]        rem_sh;
    logic [W:0]        rem_diff;
    logic              ge;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    assign rem_sh   = {rem_reg, dq_reg[2*W-1]};
    assign ge       = (rem_sh >= {1'b0, dsr_reg});
    assign rem_diff = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.wide ? STEPS_WIDE : STEPS_NARROW;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            dq_reg  <= req.wide ? req.dividend : {req.dividend[W-1:0], {W{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
            dq_reg  <= {dq_reg[2*W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg[W-1:0];
    assign rsp.remainder = rem_reg;

    `PFA_ASSERT_NEVER(a_start_while_busy, clk, rst_n,
        req.start && busy_reg, "divider restarted while busy")

endmodule

`default_nettype wire

// ----- rtl/pfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "prime_field_alu_defines.svh"

module pfa_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [pfa_pkg::DATA_WIDTH-1:0] modulus,
    input  wire logic                           q_valid,
    input  wire pfa_pkg::entry_t                q_entry,
    output logic                                q_pop,
    output pfa_pkg::div_req_t                   div_req,
    input  wire pfa_pkg::div_rsp_t              div_rsp,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pfa_pkg::DATA_WIDTH-1:0]      result,
    output logic [1:0]                          status
);
    import pfa_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = W + SW + 1;

    back_state_t           state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [W-1:0]          p_reg, p_next;
    logic [W-1:0]          a_reg, a_next;
    logic [W-1:0]          b_reg, b_next;
    logic [W-1:0]          x_reg, x_next;
    logic [W-1:0]          inv_reg, inv_next;
    logic [W-1:0]          r0_reg, r0_next;
    logic [W-1:0]          r1_reg, r1_next;
    logic signed [SW-1:0]  s0_reg, s0_next;
    logic signed [SW-1:0]  s1_reg, s1_next;
    logic [2*W-1:0]        prod_reg, prod_next;
    logic [1:0]            st_reg, st_next;
    logic                  out_valid_reg, out_valid_next;
    logic [W-1:0]          result_reg, result_next;
    logic [1:0]            status_reg, status_next;

    logic [W-1:0]          p_eff;
    logic [W:0]            add_sum;
    logic [W:0]            add_red;
    logic [W:0]            sub_red;
    logic [W-1:0]          x_sel;
    logic signed [QW-1:0]  qs_prod;
    logic signed [QW-1:0]  s0_ext;
    logic signed [QW-1:0]  s_diff;
    logic signed [SW-1:0]  p_s;
    logic signed [SW-1:0]  s_adj;
    logic signed [SW-1:0]  s_fix;

    assign p_eff   = (modulus < W'(2)) ? W'(2) : modulus;
    assign add_sum = {1'b0, a_reg} + {1'b0, b_reg};
    assign add_red = (add_sum >= {1'b0, p_reg}) ? add_sum - {1'b0, p_reg} : add_sum;
    assign sub_red = (a_reg >= b_reg) ? {1'b0, a_reg} - {1'b0, b_reg}
                                      : {1'b0, a_reg} + {1'b0, p_reg} - {1'b0, b_reg};
    assign x_sel   = (op_reg == OP_INV) ? a_reg : b_reg;

    // Cofactor update s_new = s0 - q * s1, taken straight from the divider quotient.
    assign qs_prod = $signed({1'b0, div_rsp.quotient}) * s1_reg;
    assign s0_ext  = QW'(s0_reg);
    assign s_diff  = s0_ext - qs_prod;

    // Bring the final cofactor into 0..p-1.
    assign p_s   = $signed({2'b00, p_reg});
    assign s_adj = s1_reg[SW-1] ? s1_reg + p_s : s1_reg;
    assign s_fix = (s_adj >= p_s) ? s_adj - p_s : s_adj;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        inv_next       = inv_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        prod_next      = prod_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_entry.op;
                    a_next     = q_entry.a;
                    b_next     = q_entry.b;
                    p_next     = p_eff;
                    st_next    = STAT_OK;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A:
            begin
                if (a_reg < p_reg)
                begin
                    state_next = ST_RED_B;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{W{1'b0}}, a_reg};
                    div_req.divisor  = p_reg;
                    state_next       = ST_WAIT_A;
                end
            end
            ST_WAIT_A:
            begin
                if (div_rsp.done)
                begin
                    a_next     = div_rsp.remainder;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B:
            begin
                if (b_reg < p_reg)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{W{1'b0}}, b_reg};
                    div_req.divisor  = p_reg;
                    state_next       = ST_WAIT_B;
                end
            end
            ST_WAIT_B:
            begin
                if (div_rsp.done)
                begin
                    b_next     = div_rsp.remainder;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (op_reg) inside
                    OP_ADD:
                    begin
                        out_valid_next = 1'b1;
                        result_next    = add_red[W-1:0];
                        status_next    = STAT_OK;
                    end
                    OP_SUB:
                    begin
                        out_valid_next = 1'b1;
                        result_next    = sub_red[W-1:0];
                        status_next    = STAT_OK;
                    end
                    OP_NEG:
                    begin
                        out_valid_next = 1'b1;
                        result_next    = (a_reg == '0) ? '0 : p_reg - a_reg;
                        status_next    = STAT_OK;
                    end
                    OP_EQ:
                    begin
                        out_valid_next = 1'b1;
                        result_next    = (a_reg == b_reg) ? W'(1) : '0;
                        status_next    = STAT_OK;
                    end
                    OP_MUL:
                    begin
                        prod_next  = a_reg * b_reg;
                        state_next = ST_MRED;
                    end
                    OP_INV, OP_DIV:
                    begin
                        x_next = x_sel;
                        if (x_sel == '0)
                        begin
                            st_next    = STAT_ZERO;
                            inv_next   = x_sel;
                            state_next = ST_POST_INV;
                        end
                        else
                        begin
                            r0_next    = p_reg;
                            r1_next    = x_sel;
                            s0_next    = '0;
                            s1_next    = SW'(1);
                            state_next = ST_EUC;
                        end
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                        result_next    = '0;
                        status_next    = STAT_OK;
                    end
                endcase
            end
            ST_EUC:
            begin
                if (r1_reg > W'(1))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {{W{1'b0}}, r0_reg};
                    div_req.divisor  = r1_reg;
                    state_next       = ST_EUC_WAIT;
                end
                else
                begin
                    st_next    = STAT_OK;
                    inv_next   = s_fix[W-1:0];
                    state_next = ST_POST_INV;
                end
            end
            ST_EUC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        // Remainder above one divides the modulus: no inverse exists.
                        st_next    = STAT_NOINV;
                        inv_next   = x_reg;
                        state_next = ST_POST_INV;
                    end
                    else
                    begin
                        r0_next    = r1_reg;
                        r1_next    = div_rsp.remainder;
                        s0_next    = s1_reg;
                        s1_next    = s_diff[SW-1:0];
                        state_next = ST_EUC;
                    end
                end
            end
            ST_POST_INV:
            begin
                if (op_reg == OP_INV)
                begin
                    out_valid_next = 1'b1;
                    result_next    = inv_reg;
                    status_next    = st_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    prod_next  = a_reg * inv_reg;
                    state_next = ST_MRED;
                end
            end
            ST_MRED:
            begin
                div_req.start    = 1'b1;
                div_req.wide     = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = p_reg;
                state_next       = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (div_rsp.done)
                begin
                    out_valid_next = 1'b1;
                    result_next    = div_rsp.remainder;
                    status_next    = st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        p_reg      <= p_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        x_reg      <= x_next;
        inv_reg    <= inv_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        prod_reg   <= prod_next;
        st_reg     <= st_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

    `PFA_ASSERT(a_pop_when_free, clk, rst_n,
        q_pop |-> (state_reg == ST_IDLE) && !out_valid_reg, "pop while busy")
    `PFA_ASSERT(a_result_reduced, clk, rst_n,
        out_valid_reg |-> (result_reg < p_reg), "result not reduced")
    `PFA_ASSERT(a_status_source, clk, rst_n,
        out_valid_reg && (status_reg != STAT_OK) |-> (op_reg == OP_INV) || (op_reg == OP_DIV),
        "error status on plain op")

endmodule

`default_nettype wire
